FILE: rtl/core/pcec_pkg.sv
// shared types, constants and lookup functions for the png chunk envelope checker
package pcec_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        envelope_ok;
        logic [2:0]  fault_kind;
        logic [15:0] chunks_seen;
    } t_out_item;

    typedef struct packed {
        logic [15:0] max_chunks;
        logic        check_signature;
    } t_cfg;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_HALT = 6'b100000
    } t_phase;

    localparam logic [2:0] FAULT_NONE     = 3'd0;
    localparam logic [2:0] FAULT_SIG      = 3'd1;
    localparam logic [2:0] FAULT_TOO_MANY = 3'd2;
    localparam logic [2:0] FAULT_CRC      = 3'd3;
    localparam logic [2:0] FAULT_END      = 3'd4;
    localparam logic [2:0] FAULT_TRUNC    = 3'd5;

    localparam logic       CFG_MAX_CHUNKS = 1'b0;
    localparam logic       CFG_CHECK_SIG  = 1'b1;
    localparam int         CFG_DATA_W     = 16;

    localparam logic [15:0] MAX_CHUNKS_RST = 16'd1024;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES       = 32'hFFFFFFFF;
    localparam logic [2:0]  SIG_LAST_IDX   = 3'd7;
    localparam logic [2:0]  FIELD_LAST_IDX = 3'd3;

    // png file signature, byte by byte
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd137;
            3'd1:    v = 8'd80;
            3'd2:    v = 8'd78;
            3'd3:    v = 8'd71;
            3'd4:    v = 8'd13;
            3'd5:    v = 8'd10;
            3'd6:    v = 8'd26;
            3'd7:    v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // chunk type of the end chunk, "IEND"
    function automatic logic [7:0] end_type_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'd73;
            2'd1:    v = 8'd69;
            2'd2:    v = 8'd78;
            2'd3:    v = 8'd68;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/pcec_crc8.sv
// byte-wide reflected crc-32 update
module pcec_crc8 import pcec_pkg::*; (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        o_crc = c;
    end

endmodule

FILE: rtl/core/pcec_parser.sv
// chunk parser state and per-byte update, with verdict generation
module pcec_parser import pcec_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase                r_phase,  n_phase;
    logic [2:0]            r_idx,    n_idx;
    logic [31:0]           r_len,    n_len;
    logic [31:0]           r_rem,    n_rem;
    logic [31:0]           r_crc,    n_crc;
    logic [31:0]           r_stored, n_stored;
    logic                  r_is_end, n_is_end;
    logic [COUNT_BITS-1:0] r_count,  n_count;
    logic [2:0]            r_fault,  n_fault;

    logic [31:0]     crc_upd;
    logic [COUNT_BITS:0] count_inc;
    logic            end_seen;
    logic [31:0]     count_wide;
    logic [7:0]      b;

    assign b = i_item.data_byte;

    pcec_crc8 u_crc (
        .i_crc  (r_crc),
        .i_byte (b),
        .o_crc  (crc_upd)
    );

    assign count_inc = {1'b0, r_count} + {{COUNT_BITS{1'b0}}, 1'b1};

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_len    = r_len;
        n_rem    = r_rem;
        n_crc    = r_crc;
        n_stored = r_stored;
        n_is_end = r_is_end;
        n_count  = r_count;
        n_fault  = r_fault;
        end_seen = 1'b0;

        case (r_phase)
            PH_SIG: begin
                if (i_cfg.check_signature && (b != sig_byte(r_idx))) begin
                    n_fault = FAULT_SIG;
                end
                if (r_idx == SIG_LAST_IDX) begin
                    n_idx   = 3'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], b};
                if (r_idx == FIELD_LAST_IDX) begin
                    n_idx    = 3'd0;
                    n_count  = count_inc[COUNT_BITS] ? r_count : count_inc[COUNT_BITS-1:0];
                    if (33'(count_inc) > 33'(i_cfg.max_chunks)) begin
                        n_fault = FAULT_TOO_MANY;
                    end
                    n_crc    = CRC_ONES;
                    n_rem    = {r_len[23:0], b};
                    n_is_end = 1'b1;
                    n_phase  = PH_TYPE;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_TYPE: begin
                n_crc    = crc_upd;
                n_is_end = r_is_end && (b == end_type_byte(r_idx[1:0]));
                if (r_idx == FIELD_LAST_IDX) begin
                    n_idx   = 3'd0;
                    n_phase = (r_rem != 32'd0) ? PH_DATA : PH_CRC;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_DATA: begin
                n_crc = crc_upd;
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_stored = {r_stored[23:0], b};
                if (r_idx == FIELD_LAST_IDX) begin
                    n_idx = 3'd0;
                    if ((r_crc ^ CRC_ONES) != n_stored) begin
                        n_fault = FAULT_CRC;
                    end else if (r_is_end) begin
                        if ((r_len != 32'd0) || !i_item.last_byte) begin
                            n_fault = FAULT_END;
                        end else begin
                            end_seen = 1'b1;
                        end
                    end else if (i_item.last_byte) begin
                        n_fault = FAULT_END;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_HALT: begin
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase

        if (n_fault != FAULT_NONE) begin
            n_phase = PH_HALT;
        end
    end

    // verdict from the state after this byte
    assign count_wide = 32'(n_count);

    always_comb begin
        o_result.envelope_ok = (n_fault == FAULT_NONE) && end_seen;
        o_result.fault_kind  = ((n_fault == FAULT_NONE) && !end_seen) ? FAULT_TRUNC : n_fault;
        o_result.chunks_seen = (count_wide > 32'h0000FFFF) ? 16'hFFFF : count_wide[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_phase  <= PH_SIG;
            r_idx    <= 3'd0;
            r_len    <= 32'd0;
            r_rem    <= 32'd0;
            r_crc    <= CRC_ONES;
            r_stored <= 32'd0;
            r_is_end <= 1'b0;
            r_count  <= '0;
            r_fault  <= FAULT_NONE;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_crc    <= n_crc;
            r_stored <= n_stored;
            r_is_end <= n_is_end;
            r_count  <= n_count;
            r_fault  <= n_fault;
        end
    end

endmodule

FILE: rtl/core/png_chunk_envelope_checker.sv
// top level of the png chunk envelope checker: input register, parser, result register
//
// The block takes a png file one byte per transfer, last_byte marking the final
// byte, and returns one verdict transfer per file, produced by that final byte.
// It checks the eight-byte signature (when check_signature is 1), then walks the
// chunks: big-endian length, type, data and big-endian crc, running a reflected
// crc-32 over type and data and comparing it with the stored value. Chunks are
// counted against max_chunks as their length field completes. The end chunk must
// have zero length and its last crc byte must be the final byte. The first fault
// freezes the verdict; later bytes are ignored until the final byte, after which
// the parser returns to the start-of-file state for the next file. Throughput is
// one byte per clock while no final byte waits for the result register: a byte
// sits in the input register while the byte-wide crc update and field counters
// produce the next state, and the verdict of a final byte is registered in the
// result register once that byte steps the parser. Input transfers keep flowing
// while a verdict waits on output stall; only a final byte waits for the result
// register to free up. Configuration writes are expected only between files.
module png_chunk_envelope_checker import pcec_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // verdict output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_free;
    logic      step;
    t_out_item result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_chunks      <= MAX_CHUNKS_RST;
            r_cfg.check_signature <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_CHUNKS: r_cfg.max_chunks      <= i_cfg_data;
                CFG_CHECK_SIG:  r_cfg.check_signature <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // a byte that yields no verdict always moves on; a final byte needs the result slot
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    pcec_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // verdict holds while the downstream side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/pcec_checker.sv
// port-level checker for the png chunk envelope checker, with its bind
module pcec_checker import pcec_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data
);

    // a stalled verdict stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // a stalled verdict does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("verdict changed while stalled");

    // a pass verdict carries no fault and a fault verdict is never a pass
    a_ok_vs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.envelope_ok == (o_out_data.fault_kind == FAULT_NONE)))
        else $error("pass flag disagrees with fault kind");

    // a good file holds at least its end chunk
    a_ok_has_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.envelope_ok |-> (o_out_data.chunks_seen != 16'd0))
        else $error("pass verdict with no chunks counted");

    // reset leaves no verdict pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict pending after reset");

endmodule

bind png_chunk_envelope_checker pcec_checker u_pcec_checker (.*);

FILE: tb/tb_top.sv
// self-checking testbench for png_chunk_envelope_checker: whole png files in, verdicts checked
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcec_pkg::*;

    // png file signature and the end chunk tag, first byte in the top bits
    localparam logic [63:0] PNG_MAGIC      = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IEND_TAG       = 32'h49454E44;
    localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
    localparam int unsigned TALLY_CAP      = 65535;
    // cycles with no transfer on either side before the run is declared hung
    localparam int          QUIET_LIMIT    = 2000;

    // shapes of generated files
    typedef enum int {
        FK_GOOD,
        FK_BAD_CRC,
        FK_CUT,
        FK_NO_END,
        FK_END_LEN,
        FK_END_EARLY,
        FK_BAD_SIG,
        FK_OVERRUN,
        FK_NOISE,
        FK_NEAR_END
    } t_file_kind;

    // clock, reset and block ports
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = CFG_MAX_CHUNKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    // bytes waiting for the driver, verdicts waiting for the block
    t_in_item   pending[$];
    t_out_item  verdicts_due[$];
    logic [7:0] file_buf[$];

    // handshake bookkeeping between the edges
    logic byte_taken    = 1'b0;
    logic verdict_taken = 1'b0;
    int   gap_left      = 0;
    int   hold_left     = 3;
    bit   calm_in       = 1'b0;
    bit   calm_out      = 1'b0;
    int   quiet_cycles  = 0;
    int   fail_count    = 0;
    int   sent_bytes    = 0;
    bit        got_verdict;
    t_out_item fresh_verdict;

    // parser state mirrored by the predictor
    logic [15:0] lim_chunks;
    logic        sig_check;
    t_phase      stage;
    logic [2:0]  field_pos;
    logic [31:0] len_field;
    logic [31:0] data_left;
    logic [31:0] crc_run;
    logic [31:0] crc_field;
    logic        tag_is_iend;
    int unsigned chunk_tally;
    logic [2:0]  fault_now;
    logic        iend_closed;

    png_chunk_envelope_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial forever #10 i_clk = ~i_clk;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        int          k;
        r = c ^ {24'd0, b};
        for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ REFLECTED_POLY) : (r >> 1);
        return r;
    endfunction

    // start-of-file state, also after every verdict
    function automatic void forget_file();
        stage       = PH_SIG;
        field_pos   = '0;
        len_field   = '0;
        data_left   = '0;
        crc_run     = '1;
        crc_field   = '0;
        tag_is_iend = 1'b0;
        chunk_tally = 0;
        fault_now   = FAULT_NONE;
        iend_closed = 1'b0;
    endfunction

    // advance the parser by one accepted byte; returns 1 when a verdict is due
    function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                      output t_out_item verdict);
        int unsigned next_tally;
        verdict = '0;
        // after a fault or a closed end chunk the byte is dropped
        if (fault_now == FAULT_NONE && !iend_closed) begin
            case (stage)
                PH_SIG: begin
                    if (sig_check && b != PNG_MAGIC[63 - 8 * field_pos -: 8])
                        fault_now = FAULT_SIG;
                    if (field_pos == 3'd7) begin
                        field_pos = '0;
                        stage     = PH_LEN;
                    end else begin
                        field_pos = field_pos + 3'd1;
                    end
                end
                PH_LEN: begin
                    len_field = {len_field[23:0], b};
                    if (field_pos == 3'd3) begin
                        // chunk counted once its length is complete
                        field_pos   = '0;
                        next_tally  = chunk_tally + 1;
                        chunk_tally = (next_tally > TALLY_CAP) ? TALLY_CAP : next_tally;
                        if (next_tally > {16'd0, lim_chunks})
                            fault_now = FAULT_TOO_MANY;
                        crc_run     = '1;
                        data_left   = len_field;
                        tag_is_iend = 1'b1;
                        stage       = PH_TYPE;
                    end else begin
                        field_pos = field_pos + 3'd1;
                    end
                end
                PH_TYPE: begin
                    crc_run     = crc_step(crc_run, b);
                    tag_is_iend = tag_is_iend && (b == IEND_TAG[31 - 8 * field_pos -: 8]);
                    if (field_pos == 3'd3) begin
                        field_pos = '0;
                        crc_field = '0;
                        stage     = (data_left != 0) ? PH_DATA : PH_CRC;
                    end else begin
                        field_pos = field_pos + 3'd1;
                    end
                end
                PH_DATA: begin
                    crc_run   = crc_step(crc_run, b);
                    data_left = data_left - 1;
                    if (data_left == 0)
                        stage = PH_CRC;
                end
                PH_CRC: begin
                    crc_field = {crc_field[23:0], b};
                    if (field_pos == 3'd3) begin
                        field_pos = '0;
                        // crc beats every end chunk rule
                        if (~crc_run != crc_field)
                            fault_now = FAULT_CRC;
                        else if (tag_is_iend) begin
                            if (len_field != 0 || !fin)
                                fault_now = FAULT_END;
                            else
                                iend_closed = 1'b1;
                        end else if (fin)
                            fault_now = FAULT_END;
                        else
                            stage = PH_LEN;
                    end else begin
                        field_pos = field_pos + 3'd1;
                    end
                end
                default: ;
            endcase
            if (fault_now != FAULT_NONE)
                stage = PH_HALT;
        end
        if (!fin)
            return 1'b0;
        // file ended inside the signature or a chunk
        if (fault_now == FAULT_NONE && !iend_closed)
            fault_now = FAULT_TRUNC;
        verdict.envelope_ok = (fault_now == FAULT_NONE) && iend_closed;
        verdict.fault_kind  = fault_now;
        verdict.chunks_seen = chunk_tally[15:0];
        forget_file();
        return 1'b1;
    endfunction

    // per-item wait, zero inside a calm stretch
    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    // driver: new byte only once the current one has been transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || byte_taken) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (pending.size() != 0) begin
                in_item  <= pending.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
                gap_left = draw_gap(calm_in);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // verdict side: each verdict is held off for a drawn number of cycles
    always @(negedge i_clk) begin
        if (verdict_taken) begin
            if ($urandom_range(0, 9) == 0) calm_out = !calm_out;
            hold_left = draw_gap(calm_out);
        end
        if (o_out_valid === 1'b1 && hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on every byte transfer, check every verdict transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken    <= 1'b0;
            verdict_taken <= 1'b0;
        end else begin
            byte_taken    <= in_valid && !o_in_stall;
            verdict_taken <= o_out_valid && !out_stall;
            if (in_valid && !o_in_stall) begin
                got_verdict = parse_byte(in_item.data_byte, in_item.last_byte, fresh_verdict);
                if (got_verdict)
                    verdicts_due.push_back(fresh_verdict);
            end
            if (o_out_valid && !out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict transfer with no file finished: %p", o_out_data);
                    fail_count++;
                end else begin
                    fresh_verdict = verdicts_due.pop_front();
                    if (o_out_data.envelope_ok !== fresh_verdict.envelope_ok) begin
                        $error("envelope_ok: expected %0d, got %0d",
                               fresh_verdict.envelope_ok, o_out_data.envelope_ok);
                        fail_count++;
                    end
                    if (o_out_data.fault_kind !== fresh_verdict.fault_kind) begin
                        $error("fault_kind: expected %0d, got %0d",
                               fresh_verdict.fault_kind, o_out_data.fault_kind);
                        fail_count++;
                    end
                    if (o_out_data.chunks_seen !== fresh_verdict.chunks_seen) begin
                        $error("chunks_seen: expected %0d, got %0d",
                               fresh_verdict.chunks_seen, o_out_data.chunks_seen);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("png_chunk_envelope_checker verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // register write, only while the block is idle
    task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_CHUNKS)
            lim_chunks = val;
        else
            sig_check = val[0];
    endtask

    // wait for every byte and verdict, then let the pipeline run dry
    task automatic settle(input int tail);
        while (pending.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    // signature, optionally with one bit flipped
    task automatic put_sig(input bit corrupt);
        int         at;
        int         i;
        logic [7:0] b;
        at = corrupt ? int'($urandom_range(0, 7)) : 8;
        for (i = 0; i < 8; i++) begin
            b = PNG_MAGIC[63 - 8 * i -: 8];
            if (i == at) b = b ^ 8'(1 << $urandom_range(0, 7));
            file_buf.push_back(b);
        end
    endtask

    // one chunk: length, tag, data (random or one fill value), crc
    task automatic put_chunk(input logic [31:0] len, input logic [31:0] tag,
                             input int fill, input bit corrupt);
        logic [31:0] c;
        logic [7:0]  d;
        int          i;
        for (i = 3; i >= 0; i--) file_buf.push_back(len[8 * i +: 8]);
        c = '1;
        for (i = 3; i >= 0; i--) begin
            d = tag[8 * i +: 8];
            file_buf.push_back(d);
            c = crc_step(c, d);
        end
        for (i = 0; i < int'(len); i++) begin
            d = (fill < 0) ? 8'($urandom) : 8'(fill);
            file_buf.push_back(d);
            c = crc_step(c, d);
        end
        c = ~c;
        if (corrupt) c = c ^ (32'd1 << $urandom_range(0, 31));
        for (i = 3; i >= 0; i--) file_buf.push_back(c[8 * i +: 8]);
    endtask

    // queue the first keep bytes of the file, last flag on the final one
    task automatic ship(input int keep);
        t_in_item it;
        int       i;
        for (i = 0; i < keep; i++) begin
            it.data_byte = file_buf[i];
            it.last_byte = (i == keep - 1);
            pending.push_back(it);
        end
        sent_bytes += keep;
        file_buf.delete();
    endtask

    // tag one byte away from the end chunk tag
    function automatic logic [31:0] near_iend();
        return IEND_TAG ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    endfunction

    // mostly tiny chunks, now and then a longer one
    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return 32'($urandom_range(0, 5));
        if (r < 19) return 32'($urandom_range(6, 24));
        return 32'($urandom_range(25, 60));
    endfunction

    function automatic t_file_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FK_GOOD;
        if (r < 62) return FK_BAD_CRC;
        if (r < 68) return FK_CUT;
        if (r < 72) return FK_NO_END;
        if (r < 76) return FK_END_LEN;
        if (r < 80) return FK_END_EARLY;
        if (r < 84) return FK_BAD_SIG;
        if (r < 88) return FK_OVERRUN;
        if (r < 93) return FK_NOISE;
        return FK_NEAR_END;
    endfunction

    // build one file of the given shape and queue it
    task automatic make_file(input t_file_kind kind);
        int          n;
        int          k;
        int          bad;
        int          keep;
        logic [31:0] tag;
        if (kind == FK_NOISE) begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) file_buf.push_back(8'($urandom));
            keep = n;
        end else begin
            put_sig(kind == FK_BAD_SIG);
            n = $urandom_range((kind == FK_NO_END || kind == FK_NEAR_END) ? 1 : 0, 3);
            // index n stands for the end chunk
            bad = (kind == FK_BAD_CRC) ? int'($urandom_range(0, n)) : -1;
            for (k = 0; k < n; k++) begin
                tag = (kind == FK_NEAR_END) ? near_iend() : $urandom;
                put_chunk(pick_len(), tag, -1, k == bad);
            end
            if (kind == FK_OVERRUN) begin
                // length far beyond what the file holds
                tag = $urandom | 32'h0100_0000;
                for (k = 3; k >= 0; k--) file_buf.push_back(tag[8 * k +: 8]);
                repeat ($urandom_range(4, 10)) file_buf.push_back(8'($urandom));
            end else if (kind != FK_NO_END &&
                         !(kind == FK_NEAR_END && $urandom_range(0, 1) == 0)) begin
                put_chunk((kind == FK_END_LEN) ? 32'($urandom_range(1, 4)) : 32'd0,
                          IEND_TAG, -1, bad == n);
            end
            // trailing bytes after a correct end chunk
            if (kind == FK_END_EARLY)
                repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom));
            keep = (kind == FK_CUT) ? int'($urandom_range(1, file_buf.size() - 1))
                                    : file_buf.size();
        end
        ship(keep);
    endtask

    task automatic random_phase(input int min_files, input int min_bytes);
        int files;
        int start;
        files = 0;
        start = sent_bytes;
        while (files < min_files || sent_bytes - start < min_bytes) begin
            make_file(pick_kind());
            files++;
        end
    endtask

    initial begin
        lim_chunks = MAX_CHUNKS_RST;
        sig_check  = 1'b1;
        forget_file();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed files, registers at their reset values
        // smallest good file: signature and an empty end chunk
        put_sig(1'b0);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        // empty chunk, all-zero and all-one data, then the end chunk
        put_sig(1'b0);
        put_chunk(32'd0, $urandom, -1, 1'b0);
        put_chunk(32'd3, $urandom, 8'h00, 1'b0);
        put_chunk(32'd4, $urandom, 8'hFF, 1'b0);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        // single-byte files
        file_buf.push_back(8'hFF);
        ship(1);
        file_buf.push_back(8'h00);
        ship(1);
        // file ends inside the signature
        put_sig(1'b0);
        ship(7);
        // signature mismatch
        put_sig(1'b1);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        // crc mismatch on a data chunk
        put_sig(1'b0);
        put_chunk(32'd3, $urandom, -1, 1'b1);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        // crc mismatch wins over a nonzero end chunk length
        put_sig(1'b0);
        put_chunk(32'd2, IEND_TAG, -1, 1'b1);
        ship(file_buf.size());
        // file ends on an ordinary chunk
        put_sig(1'b0);
        put_chunk(32'd2, $urandom, 8'hFF, 1'b0);
        ship(file_buf.size());
        // end chunk with data
        put_sig(1'b0);
        put_chunk(32'd1, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        // end chunk followed by one more byte
        put_sig(1'b0);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        file_buf.push_back(8'($urandom));
        ship(file_buf.size());
        // all-ones length, file runs out inside the data
        put_sig(1'b0);
        put_chunk(32'd0, $urandom, -1, 1'b0);
        file_buf.delete();
        put_sig(1'b0);
        repeat (4) file_buf.push_back(8'hFF);
        repeat (7) file_buf.push_back(8'($urandom));
        ship(file_buf.size());
        // file ends inside the end chunk crc
        put_sig(1'b0);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size() - 2);
        // last chunk tag one byte off the end tag
        put_sig(1'b0);
        put_chunk(32'd0, near_iend(), -1, 1'b0);
        ship(file_buf.size());
        // bytes after a fault are dropped up to the final byte
        put_sig(1'b0);
        put_chunk(32'd1, $urandom, -1, 1'b1);
        put_chunk(32'd2, $urandom, -1, 1'b0);
        put_chunk(32'd0, IEND_TAG, -1, 1'b0);
        ship(file_buf.size());
        settle(8);

        // one chunk allowed, signature ignored
        cfg_write(CFG_MAX_CHUNKS, 16'd1);
        cfg_write(CFG_CHECK_SIG, {15'($urandom), 1'b0});
        random_phase(2, 40);
        settle(8);

        // no chunk allowed at all
        cfg_write(CFG_MAX_CHUNKS, 16'd0);
        cfg_write(CFG_CHECK_SIG, {15'($urandom), 1'b1});
        random_phase(1, 0);
        settle(8);

        // widest limit
        cfg_write(CFG_MAX_CHUNKS, 16'hFFFF);
        random_phase(2, 40);
        settle(8);

        // tight limit, signature ignored
        cfg_write(CFG_MAX_CHUNKS, 16'($urandom_range(2, 5)));
        cfg_write(CFG_CHECK_SIG, {15'($urandom), 1'b0});
        random_phase(2, 40);
        settle(8);

        // arbitrary roomy limit, signature checked
        cfg_write(CFG_CHECK_SIG, {15'($urandom), 1'b1});
        cfg_write(CFG_MAX_CHUNKS, 16'($urandom_range(6, 65534)));
        random_phase(2, 40);
        settle(8);

        // limit right at a typical chunk count
        cfg_write(CFG_MAX_CHUNKS, 16'd3);
        random_phase(2, 40);
        settle(12);

        if (fail_count == 0)
            $display("png_chunk_envelope_checker verification clean");
        else
            $display("png_chunk_envelope_checker verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pcec_pkg.sv
rtl/core/pcec_crc8.sv
rtl/core/pcec_parser.sv
rtl/core/png_chunk_envelope_checker.sv
rtl/core/pcec_checker.sv
tb/tb_top.sv
